FILE: rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Shared constants, operation codes and status codes of the heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 32;
    localparam int COUNT_BITS   = 7;
    localparam int STATUS_BITS  = 2;

    typedef logic [STATUS_BITS-1:0] t_status;

    localparam logic    KIND_INSERT  = 1'b0;
    localparam logic    KIND_REMOVE  = 1'b1;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/mhpq_if.sv
// ----------------------------------------------------------------------------
// Min-heap priority queue channels
// Valid/ready channels for operation requests and for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhpq_in_if #(
    parameter int KEY_BITS = mhpq_pkg::KEY_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic signed [KEY_BITS-1:0] key_value;

    modport source (output valid, output kind, output key_value, input ready);
    modport sink   (input valid, input kind, input key_value, output ready);
endinterface

interface mhpq_out_if #(
    parameter int KEY_BITS = mhpq_pkg::KEY_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic signed [KEY_BITS-1:0]       removed_key;
    logic signed [KEY_BITS-1:0]       min_key;
    logic [mhpq_pkg::COUNT_BITS-1:0]  entry_count;
    mhpq_pkg::t_status                status;

    modport source (output valid, output removed_key, output min_key,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input removed_key, input min_key,
                    input entry_count, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/mhpq_store.sv
// ----------------------------------------------------------------------------
// Heap key store
// Synchronous memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_store #(
    parameter int DEPTH = mhpq_pkg::CAPACITY_DEF,
    parameter int WIDTH = mhpq_pkg::KEY_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

FILE: rtl/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// Heap sift controller
// Runs sift-up for inserts and sift-down for removals against the key store,
// keeps the count and a copy of the root, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ctrl #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = mhpq_pkg::KEY_BITS_DEF,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_kind,
    input  wire logic signed [KEY_BITS-1:0] i_key_value,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic signed [KEY_BITS-1:0]      o_removed_key,
    output logic signed [KEY_BITS-1:0]      o_min_key,
    output logic [mhpq_pkg::COUNT_BITS-1:0] o_entry_count,
    output mhpq_pkg::t_status               o_status,
    output logic                            o_we,
    output logic [AW-1:0]                   o_waddr,
    output logic [KEY_BITS-1:0]             o_wdata,
    output logic [AW-1:0]                   o_raddr_a,
    output logic [AW-1:0]                   o_raddr_b,
    input  wire logic [KEY_BITS-1:0]        i_rdata_a,
    input  wire logic [KEY_BITS-1:0]        i_rdata_b
);

    import mhpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_CMP  = 3'd1;
    localparam logic [2:0] S_DN_LAST = 3'd2;
    localparam logic [2:0] S_DN_CMP  = 3'd3;
    localparam logic [2:0] S_FIN     = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]                 r_state, n_state;
    logic signed [KEY_BITS-1:0] r_key, n_key;
    logic [AW-1:0]              r_at, n_at;
    logic [CW-1:0]              r_count, n_count;
    logic signed [KEY_BITS-1:0] r_root;
    logic signed [KEY_BITS-1:0] r_removed, n_removed;
    t_status                    r_status, n_status;

    logic                       r_ovalid;
    logic signed [KEY_BITS-1:0] r_o_removed;
    logic signed [KEY_BITS-1:0] r_o_min;
    logic [CW-1:0]              r_o_count;
    t_status                    r_o_status;

    logic                       accept;
    logic                       load_out;
    logic [AW-1:0]              up_idx;
    logic [AW-1:0]              up_up_idx;
    logic [IW-1:0]              size_w;
    logic [IW-1:0]              left_idx;
    logic [IW-1:0]              right_idx;
    logic                       pick_right;
    logic [IW-1:0]              pick_idx;
    logic signed [KEY_BITS-1:0] pick_key;
    logic signed [KEY_BITS-1:0] key_a;
    logic signed [KEY_BITS-1:0] key_b;
    logic [IW-1:0]              next_left;
    logic [IW-1:0]              next_right;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign load_out = (r_state == S_DONE) && (!r_ovalid || i_ready);

    assign key_a      = i_rdata_a;
    assign key_b      = i_rdata_b;
    assign up_idx     = (r_at - AW'(1)) >> 1;
    assign up_up_idx  = (up_idx - AW'(1)) >> 1;
    assign size_w     = IW'(r_count);
    assign left_idx   = IW'({r_at, 1'b1});
    assign right_idx  = left_idx + IW'(1);
    assign pick_right = (right_idx < size_w) && !(key_a < key_b);
    assign pick_idx   = pick_right ? right_idx : left_idx;
    assign pick_key   = pick_right ? key_b : key_a;
    assign next_left  = IW'({pick_idx[AW-1:0], 1'b1});
    assign next_right = next_left + IW'(1);

    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_at      = r_at;
        n_count   = r_count;
        n_removed = r_removed;
        n_status  = r_status;
        o_we      = 1'b0;
        o_waddr   = r_at;
        o_wdata   = r_key;
        o_raddr_a = '0;
        o_raddr_b = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_removed = '0;
                    n_status  = STATUS_OK;
                    if (i_kind == KIND_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = STATUS_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_key   = i_key_value;
                            n_count = r_count + CW'(1);
                            n_at    = AW'(r_count);
                            if (r_count == '0) begin
                                o_we    = 1'b1;
                                o_waddr = '0;
                                o_wdata = i_key_value;
                                n_state = S_DONE;
                            end else begin
                                o_raddr_a = (AW'(r_count) - AW'(1)) >> 1;
                                n_state   = S_UP_CMP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STATUS_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_removed = r_root;
                            n_count   = r_count - CW'(1);
                            if (r_count == CW'(1)) begin
                                n_state = S_DONE;
                            end else begin
                                o_raddr_a = AW'(r_count - CW'(1));
                                n_state   = S_DN_LAST;
                            end
                        end
                    end
                end
            end
            S_UP_CMP: begin
                o_we = 1'b1;
                if (r_key < key_a) begin
                    o_wdata = key_a;
                    n_at    = up_idx;
                    if (up_idx == '0) begin
                        n_state = S_FIN;
                    end else begin
                        o_raddr_a = up_up_idx;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DN_LAST: begin
                n_key     = key_a;
                n_at      = '0;
                o_raddr_a = AW'(1);
                o_raddr_b = (r_count > CW'(2)) ? AW'(2) : AW'(1);
                n_state   = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_we = 1'b1;
                if (pick_key < r_key) begin
                    o_wdata = pick_key;
                    n_at    = pick_idx[AW-1:0];
                    if (next_left < size_w) begin
                        o_raddr_a = next_left[AW-1:0];
                        o_raddr_b = (next_right < size_w) ? next_right[AW-1:0]
                                                          : next_left[AW-1:0];
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FIN: begin
                o_we    = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_at      <= n_at;
        r_removed <= n_removed;
        r_status  <= n_status;
        if (o_we && (o_waddr == '0)) begin
            r_root <= o_wdata;
        end
        if (load_out) begin
            r_o_removed <= r_removed;
            r_o_min     <= (r_count != '0) ? r_root : '0;
            r_o_count   <= r_count;
            r_o_status  <= r_status;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_removed_key = r_o_removed;
    assign o_min_key     = r_o_min;
    assign o_entry_count = COUNT_BITS'(r_o_count);
    assign o_status      = r_o_status;

endmodule

`default_nettype wire

FILE: rtl/min_heap_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Min-heap priority queue core
// Binary min-heap of signed keys in a synchronous store, with insert and
// remove-minimum operations, one result per request.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer carries
// i_in      in         kind, key_value
// o_res     out        removed_key, min_key, entry_count, status
//
// An insert runs sift-up and a remove runs sift-down, over L heap levels with L up to
// log2(CAPACITY); one level is one read/compare/write of the store.
// Dropped inserts, empty removes and trivial cases finish without a sift.
// A new request is taken only after the previous one is in the result register;
// a held result stalls the core only when the next result is ready.
// Reset clears the count; the store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module min_heap_priority_queue_core #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = mhpq_pkg::KEY_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mhpq_in_if.sink   i_in,
    mhpq_out_if.source o_res
);

    import mhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                we;
    logic [AW-1:0]       waddr;
    logic [KEY_BITS-1:0] wdata;
    logic [AW-1:0]       raddr_a;
    logic [AW-1:0]       raddr_b;
    logic [KEY_BITS-1:0] rdata_a;
    logic [KEY_BITS-1:0] rdata_b;

    mhpq_ctrl #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .AW       (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_kind        (i_in.kind),
        .i_key_value   (i_in.key_value),
        .o_valid       (o_res.valid),
        .i_ready       (o_res.ready),
        .o_removed_key (o_res.removed_key),
        .o_min_key     (o_res.min_key),
        .o_entry_count (o_res.entry_count),
        .o_status      (o_res.status),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_raddr_a     (raddr_a),
        .o_raddr_b     (raddr_b),
        .i_rdata_a     (rdata_a),
        .i_rdata_b     (rdata_b)
    );

    mhpq_store #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_BITS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

endmodule

`default_nettype wire
